// File: rtl/gprke_pkg.sv
// ----------------------------------------------------------------------------
// gprke_pkg
// Shared types, codes and tables of the gamepad report and keystroke engine.
// ----------------------------------------------------------------------------
package gprke_pkg;

  typedef enum logic [1:0] {
    OP_ASSIGN = 2'd0,
    OP_REPORT = 2'd1,
    OP_POLL   = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_EVENT = 2'd1,
    ST_NO_PAD   = 2'd2
  } status_e;

  // configuration register indexes
  localparam logic [1:0] CFG_TRIG_THR  = 2'd0;
  localparam logic [1:0] CFG_STICK_THR = 2'd1;

  localparam logic [7:0]  TRIG_THR_RST  = 8'd30;
  localparam logic [14:0] STICK_THR_RST = 15'd20000;

  localparam logic [7:0]  TRIG_FULL = 8'd255;
  localparam int unsigned RAW_LT_BIT = 10;
  localparam int unsigned RAW_RT_BIT = 11;
  localparam int unsigned RAW_BTN_N  = 10;

  // button bits that produce key events (bits 10 and 11 are unused)
  localparam logic [15:0] EVENT_MASK = 16'hF3FF;

  localparam logic [4:0] KEY_TRIG_L  = 5'd14;
  localparam logic [4:0] KEY_TRIG_R  = 5'd15;
  localparam logic [4:0] KEY_LSTICK  = 5'd16;
  localparam logic [4:0] KEY_RSTICK  = 5'd24;

  // axis quantization
  localparam logic [1:0] AX_OFF  = 2'd0;
  localparam logic [1:0] AX_LOW  = 2'd1;
  localparam logic [1:0] AX_HIGH = 2'd2;

  localparam logic [3:0] DIR_NONE = 4'd8;

  localparam logic [15:0] RAW_TO_MASK [RAW_BTN_N] = '{
    16'h1000, 16'h2000, 16'h4000, 16'h8000, 16'h0100,
    16'h0200, 16'h0020, 16'h0010, 16'h0040, 16'h0080
  };

  localparam logic [15:0] DPAD_MASK [8] = '{
    16'h1, 16'h9, 16'h8, 16'hA, 16'h2, 16'h6, 16'h4, 16'h5
  };

  typedef struct packed {
    op_e                op;
    logic signed [31:0] pad_id;
    logic               report_valid;
    logic [15:0]        raw_buttons;
    logic [7:0]         dpad_code;
    logic signed [15:0] raw_left_x;
    logic signed [15:0] raw_left_y;
    logic signed [15:0] raw_right_x;
    logic signed [15:0] raw_right_y;
  } gprke_in_t;

  typedef struct packed {
    status_e            status;
    logic [4:0]         key_code;
    logic               key_up;
    logic [15:0]        button_word;
    logic [7:0]         left_trigger_out;
    logic [7:0]         right_trigger_out;
    logic signed [15:0] left_x_out;
    logic signed [15:0] left_y_out;
    logic signed [15:0] right_x_out;
    logic signed [15:0] right_y_out;
    logic [31:0]        packet_count;
  } gprke_out_t;

  // pad snapshot; also the shape of the last-event record
  typedef struct packed {
    logic [15:0]        buttons;
    logic [7:0]         trig_l;
    logic [7:0]         trig_r;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
  } pad_t;

  typedef struct packed {
    logic       found;
    logic [4:0] code;
    logic       up;
    pad_t       last_next;
  } event_t;

  // direction offset by quantized y and x
  function automatic logic [3:0] dir_lookup(logic [1:0] ys, logic [1:0] xs);
    logic [3:0] d;
    d = DIR_NONE;
    unique case (ys)
      AX_OFF: begin
        unique case (xs)
          AX_LOW:  d = 4'd3;
          AX_HIGH: d = 4'd2;
          default: d = DIR_NONE;
        endcase
      end
      AX_LOW: begin
        unique case (xs)
          AX_LOW:  d = 4'd7;
          AX_HIGH: d = 4'd6;
          default: d = 4'd1;
        endcase
      end
      AX_HIGH: begin
        unique case (xs)
          AX_LOW:  d = 4'd4;
          AX_HIGH: d = 4'd5;
          default: d = 4'd0;
        endcase
      end
      default: d = DIR_NONE;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/gprke_report_map.sv
// ----------------------------------------------------------------------------
// gprke_report_map
// Remaps one raw state report into the standard pad snapshot.
// ----------------------------------------------------------------------------
module gprke_report_map (
  input  gprke_pkg::gprke_in_t item_i,
  output gprke_pkg::pad_t      pad_o
);
  import gprke_pkg::*;

  logic [15:0] btn;

  always_comb begin
    btn = '0;
    for (int i = 0; i < RAW_BTN_N; i++) begin
      if (item_i.raw_buttons[i]) btn = btn | RAW_TO_MASK[i];
    end
    if (item_i.dpad_code[7:3] == 5'd0) btn = btn | DPAD_MASK[item_i.dpad_code[2:0]];
  end

  always_comb begin
    pad_o.buttons = btn;
    pad_o.trig_l  = item_i.raw_buttons[RAW_LT_BIT] ? TRIG_FULL : 8'd0;
    pad_o.trig_r  = item_i.raw_buttons[RAW_RT_BIT] ? TRIG_FULL : 8'd0;
    pad_o.lx      = item_i.raw_left_x;
    pad_o.ly      = 16'sd0 - item_i.raw_left_y;   // wraps at -32768
    pad_o.rx      = item_i.raw_right_x;
    pad_o.ry      = 16'sd0 - item_i.raw_right_y;
  end

endmodule

// File: rtl/gprke_event_pick.sv
// ----------------------------------------------------------------------------
// gprke_event_pick
// Picks the next keystroke event and the updated last-event record.
// ----------------------------------------------------------------------------
module gprke_event_pick (
  input  gprke_pkg::pad_t   pad_i,
  input  gprke_pkg::pad_t   last_i,
  input  logic [7:0]        trig_thr_i,
  input  logic [14:0]       stick_thr_i,
  output gprke_pkg::event_t ev_o
);
  import gprke_pkg::*;

  function automatic logic [1:0] axis_q(logic signed [15:0] v, logic [14:0] t);
    logic signed [16:0] s;
    logic signed [16:0] tp;
    s  = {v[15], v};
    tp = signed'({2'b00, t});
    if (s > tp) return AX_HIGH;
    else if (s < -tp) return AX_LOW;
    else return AX_OFF;
  endfunction

  logic [15:0] diff;
  logic [3:0]  pick;
  logic        on_l, was_l, on_r, was_r;
  logic [3:0]  cur_l, lst_l, cur_r, lst_r;

  assign diff  = (pad_i.buttons ^ last_i.buttons) & EVENT_MASK;
  assign on_l  = pad_i.trig_l  > trig_thr_i;
  assign was_l = last_i.trig_l > trig_thr_i;
  assign on_r  = pad_i.trig_r  > trig_thr_i;
  assign was_r = last_i.trig_r > trig_thr_i;
  assign cur_l = dir_lookup(axis_q(pad_i.ly, stick_thr_i), axis_q(pad_i.lx, stick_thr_i));
  assign lst_l = dir_lookup(axis_q(last_i.ly, stick_thr_i), axis_q(last_i.lx, stick_thr_i));
  assign cur_r = dir_lookup(axis_q(pad_i.ry, stick_thr_i), axis_q(pad_i.rx, stick_thr_i));
  assign lst_r = dir_lookup(axis_q(last_i.ry, stick_thr_i), axis_q(last_i.rx, stick_thr_i));

  // lowest changed button wins
  always_comb begin
    pick = '0;
    for (int i = 15; i >= 0; i--) begin
      if (diff[i]) pick = 4'(i);
    end
  end

  always_comb begin
    ev_o.found     = 1'b1;
    ev_o.code      = '0;
    ev_o.up        = 1'b0;
    ev_o.last_next = last_i;
    if (diff != 16'd0) begin
      // bits 12..15 map to codes 10..13
      ev_o.code = (pick < 4'd10) ? {1'b0, pick} : {1'b0, pick} - 5'd2;
      ev_o.up   = ~pad_i.buttons[pick];
      ev_o.last_next.buttons[pick] = pad_i.buttons[pick];
    end else if (on_l != was_l) begin
      ev_o.code = KEY_TRIG_L;
      ev_o.up   = ~on_l;
      ev_o.last_next.trig_l = pad_i.trig_l;
    end else if (on_r != was_r) begin
      ev_o.code = KEY_TRIG_R;
      ev_o.up   = ~on_r;
      ev_o.last_next.trig_r = pad_i.trig_r;
    end else if (cur_l != lst_l) begin
      if (lst_l != DIR_NONE) begin
        ev_o.code = KEY_LSTICK + {1'b0, lst_l};
        ev_o.up   = 1'b1;
        ev_o.last_next.lx = '0;
        ev_o.last_next.ly = '0;
      end else begin
        ev_o.code = KEY_LSTICK + {1'b0, cur_l};
        ev_o.last_next.lx = pad_i.lx;
        ev_o.last_next.ly = pad_i.ly;
      end
    end else begin
      // left unchanged: it follows the pad, then the right stick is checked
      ev_o.last_next.lx = pad_i.lx;
      ev_o.last_next.ly = pad_i.ly;
      if (cur_r != lst_r) begin
        if (lst_r != DIR_NONE) begin
          ev_o.code = KEY_RSTICK + {1'b0, lst_r};
          ev_o.up   = 1'b1;
          ev_o.last_next.rx = '0;
          ev_o.last_next.ry = '0;
        end else begin
          ev_o.code = KEY_RSTICK + {1'b0, cur_r};
          ev_o.last_next.rx = pad_i.rx;
          ev_o.last_next.ry = pad_i.ry;
        end
      end else begin
        ev_o.found = 1'b0;
        ev_o.last_next.rx = pad_i.rx;
        ev_o.last_next.ry = pad_i.ry;
      end
    end
  end

endmodule

// File: rtl/gamepad_report_keystroke_engine.sv
// ----------------------------------------------------------------------------
// gamepad_report_keystroke_engine
// Single-pad front end: id assignment, state reports, keystroke polls, reads.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): one item per
//   transfer, op selects assign id, state report, keystroke poll or read.
//   Output channel (out_valid_o / out_stall_i / out_data_o): exactly one
//   result per item, in order: status, key event and the stored pad state.
//   Config channel (cfg_valid_i / cfg_ready_o): index 0 trigger threshold,
//   index 1 stick threshold; always ready. Write only while idle.
// Timing:
//   An accepted item is held in the input register while the combinational
//   state update runs; when the result register is free or is emptied, the
//   result is registered and out_valid_o rises, and the result can then
//   transfer. One item per cycle sustained while out_stall_i is low; the
//   pace is set by the input register feeding the result register, the pad
//   state being updated in the same cycle.
// Reset:
//   Pad disconnected, id, pad state, counter and last-event record zero;
//   thresholds back to 30 and 20000.
// Stall:
//   While a result waits, one more item is held in the input register;
//   in_stall_o rises only when both are full.
// ----------------------------------------------------------------------------
module gamepad_report_keystroke_engine (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  gprke_pkg::gprke_in_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output gprke_pkg::gprke_out_t  out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [15:0]            cfg_data_i
);
  import gprke_pkg::*;

  // input register
  logic       s1_valid_q, s1_valid_d;
  gprke_in_t  s1_q;
  logic       s1_adv, in_accept;

  // result register
  logic       out_valid_q, out_valid_d;
  gprke_out_t out_q, out_d;

  // thresholds
  logic [7:0]  trig_thr_q;
  logic [14:0] stick_thr_q;

  // pad state
  logic        conn_q, conn_d;
  logic [31:0] id_q, id_d;
  pad_t        pad_q, pad_d;
  logic [31:0] cnt_q, cnt_d;
  pad_t        last_q, last_d;

  pad_t        rep_pad;
  event_t      ev;
  logic        id_pos;

  // the result register is free, or is emptied at this edge
  assign s1_adv      = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o  = s1_valid_q & out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign s1_valid_d  = in_accept | (s1_valid_q & ~s1_adv);
  assign out_valid_d = s1_adv | (out_valid_q & out_stall_i);
  assign cfg_ready_o = 1'b1;

  gprke_report_map u_map (
    .item_i (s1_q),
    .pad_o  (rep_pad)
  );

  gprke_event_pick u_pick (
    .pad_i       (pad_q),
    .last_i      (last_q),
    .trig_thr_i  (trig_thr_q),
    .stick_thr_i (stick_thr_q),
    .ev_o        (ev)
  );

  assign id_pos = (s1_q.pad_id != 32'sd0) & ~s1_q.pad_id[31];

  // state update for the item in the input register
  always_comb begin
    conn_d = conn_q;
    id_d   = id_q;
    pad_d  = pad_q;
    cnt_d  = cnt_q;
    last_d = last_q;
    out_d  = '0;
    out_d.status = ST_NO_PAD;
    unique case (s1_q.op)
      OP_ASSIGN: begin
        if (id_pos) begin
          id_d = unsigned'(s1_q.pad_id);
          if (!conn_q) begin
            // fresh connect clears the pad
            pad_d  = '0;
            cnt_d  = '0;
            conn_d = 1'b1;
          end
        end else if (s1_q.pad_id == 32'sd0) begin
          id_d   = '0;
          conn_d = 1'b0;
        end
        out_d.status = conn_d ? ST_OK : ST_NO_PAD;
      end
      OP_REPORT: begin
        if (conn_q) begin
          if (!s1_q.report_valid || (unsigned'(s1_q.pad_id) != id_q)) begin
            conn_d = 1'b0;
            pad_d  = '0;
            cnt_d  = '0;
          end else begin
            pad_d  = rep_pad;
            cnt_d  = cnt_q + 32'd1;
            out_d.status = ST_OK;
          end
        end
      end
      OP_POLL: begin
        if (conn_q) begin
          last_d = ev.last_next;
          if (ev.found) begin
            out_d.status   = ST_OK;
            out_d.key_code = ev.code;
            out_d.key_up   = ev.up;
          end else begin
            out_d.status = ST_NO_EVENT;
          end
        end
      end
      OP_READ: out_d.status = conn_q ? ST_OK : ST_NO_PAD;
      default: out_d.status = ST_NO_PAD;
    endcase
    out_d.button_word       = pad_d.buttons;
    out_d.left_trigger_out  = pad_d.trig_l;
    out_d.right_trigger_out = pad_d.trig_r;
    out_d.left_x_out        = pad_d.lx;
    out_d.left_y_out        = pad_d.ly;
    out_d.right_x_out       = pad_d.rx;
    out_d.right_y_out       = pad_d.ry;
    out_d.packet_count      = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      trig_thr_q  <= TRIG_THR_RST;
      stick_thr_q <= STICK_THR_RST;
      conn_q      <= 1'b0;
      id_q        <= '0;
      pad_q       <= '0;
      cnt_q       <= '0;
      last_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_TRIG_THR) trig_thr_q <= cfg_data_i[7:0];
        else if (cfg_index_i == CFG_STICK_THR) stick_thr_q <= cfg_data_i[14:0];
      end
      if (s1_adv) begin
        conn_q <= conn_d;
        id_q   <= id_d;
        pad_q  <= pad_d;
        cnt_q  <= cnt_d;
        last_q <= last_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) s1_q <= in_data_i;
    if (s1_adv) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a connected pad always holds a positive id
  a_conn_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conn_q |-> (id_q != 32'd0) && !id_q[31])
    else $error("connected with a non-positive id");

  // input side stalls only with both registers full and the output stalled
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_o && out_stall_i)
    else $error("input stalled without backpressure");

  // no-event status comes only from a poll
  a_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (s1_q.op != OP_POLL) |=> out_data_o.status != ST_NO_EVENT)
    else $error("no-event status for a non-poll item");

  // an accepted report advances the packet count by one
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (s1_q.op == OP_REPORT) && (out_d.status == ST_OK)
    |=> cnt_q == $past(cnt_q) + 32'd1)
    else $error("packet count did not advance");

endmodule
